/* rtl/pss_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the periodic sample sequencer.
// No dependencies; every other file of the block refers to this package.

package pss_pkg;

	localparam int DATA_W = 32;
	localparam int DEFAULT_COUNTER_WIDTH = 32;

	// Item kinds on the input channel.
	localparam logic ACTION_TICK = 1'b0;
	localparam logic ACTION_SET  = 1'b1;

	// Requested and pending mode codes.
	localparam logic [1:0] MODE_STAND_BY = 2'd0;
	localparam logic [1:0] MODE_START    = 2'd1;
	localparam logic [1:0] MODE_PAUSE    = 2'd2;
	localparam logic [1:0] MODE_LIMIT    = 2'd3;

	localparam logic [DATA_W-1:0] RESET_PERIOD  = 32'd5;
	localparam logic [DATA_W-1:0] COUNT_ENDLESS = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_COMMIT
	} pss_state_t;

	typedef struct packed {
		logic capture;    // latch the input transaction
		logic div_start;  // start elapsed modulo period
		logic commit;     // update state and load the result register
	} pss_cmd_t;

	typedef struct packed {
		logic div_done;   // last remainder step happens this cycle
	} pss_status_t;

endpackage

/* rtl/pss_rem.sv */
`timescale 1ns / 1ps
// Restoring remainder unit: dividend modulo divisor, one dividend bit per cycle.
// Depends on pss_pkg for the data width.

module pss_rem #(
	parameter int COUNTER_WIDTH = pss_pkg::DEFAULT_COUNTER_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [COUNTER_WIDTH-1:0]    dividend,
	input  logic [pss_pkg::DATA_W-1:0]  divisor,
	output logic                        done,
	output logic [pss_pkg::DATA_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(COUNTER_WIDTH + 1);

	logic                       busy_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [COUNTER_WIDTH-1:0]   quo_q;
	logic [pss_pkg::DATA_W-1:0] div_q;
	logic [pss_pkg::DATA_W-1:0] rem_q;
	logic [pss_pkg::DATA_W:0]   shifted;
	logic [pss_pkg::DATA_W:0]   diff;
	logic [pss_pkg::DATA_W-1:0] rem_next;

	assign shifted = {rem_q, quo_q[COUNTER_WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};
	// A clear borrow means the shifted remainder reached the divisor.
	assign rem_next = diff[pss_pkg::DATA_W] ? shifted[pss_pkg::DATA_W-1:0]
		: diff[pss_pkg::DATA_W-1:0];

	assign done      = busy_q && (cnt_q == CNT_W'(1));
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(COUNTER_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_q << 1;
			rem_q <= rem_next;
		end
	end

endmodule

/* rtl/pss_dp.sv */
`timescale 1ns / 1ps
// Datapath: input capture, sequencer state, tick and set update, result register.
// Depends on pss_pkg and instantiates pss_rem.

module pss_dp #(
	parameter int COUNTER_WIDTH = pss_pkg::DEFAULT_COUNTER_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pss_pkg::pss_cmd_t                  cmd,
	output pss_pkg::pss_status_t               status,
	input  logic                               action,
	input  logic [1:0]                         requested_mode,
	input  logic [pss_pkg::DATA_W-1:0]         step_seconds,
	input  logic signed [pss_pkg::DATA_W-1:0]  sample_count,
	output logic                               accepted,
	output logic                               sample_trigger,
	output logic                               sampling_now,
	output logic signed [pss_pkg::DATA_W-1:0]  samples_remaining
);

	// Captured transaction.
	logic                       act_q;
	logic [1:0]                 req_q;
	logic [pss_pkg::DATA_W-1:0] step_q;
	logic [pss_pkg::DATA_W-1:0] count_in_q;

	// Sequencer state.
	logic                       mode_q;
	logic [1:0]                 pend_q;
	logic [pss_pkg::DATA_W-1:0] period_q;
	logic [pss_pkg::DATA_W-1:0] remain_q;
	logic [COUNTER_WIDTH-1:0]   elapsed_q;

	// Result register.
	logic                       ok_q;
	logic                       trig_q;
	logic                       samp_q;
	logic [pss_pkg::DATA_W-1:0] res_count_q;

	logic                       div_done;
	logic [pss_pkg::DATA_W-1:0] rem;

	logic                       mode_n;
	logic [1:0]                 pend_n;
	logic [pss_pkg::DATA_W-1:0] period_n;
	logic [pss_pkg::DATA_W-1:0] remain_n;
	logic [COUNTER_WIDTH-1:0]   elapsed_n;
	logic                       ok_n;
	logic                       trig_n;
	logic                       set_valid;

	pss_rem #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(elapsed_q),
		.divisor(period_q),
		.done(div_done),
		.remainder(rem)
	);

	assign status.div_done = div_done;

	// A count is legal when it is not negative or exactly endless.
	assign set_valid = (req_q < pss_pkg::MODE_LIMIT) && (step_q != '0)
		&& (!count_in_q[pss_pkg::DATA_W-1] || (count_in_q == pss_pkg::COUNT_ENDLESS));

	always_comb begin
		mode_n    = mode_q;
		pend_n    = pend_q;
		period_n  = period_q;
		remain_n  = remain_q;
		elapsed_n = elapsed_q;
		ok_n      = 1'b0;
		trig_n    = 1'b0;
		if (act_q == pss_pkg::ACTION_SET) begin
			if (set_valid) begin
				pend_n   = req_q;
				period_n = step_q;
				remain_n = count_in_q;
				ok_n     = 1'b1;
			end
		end else begin
			if (pend_q == pss_pkg::MODE_START) begin
				mode_n = 1'b1;
				pend_n = pss_pkg::MODE_STAND_BY;
			end else if (pend_q == pss_pkg::MODE_PAUSE) begin
				mode_n = 1'b0;
				pend_n = pss_pkg::MODE_STAND_BY;
			end
			if (mode_n) begin
				if (remain_q == '0) begin
					mode_n = 1'b0;
					pend_n = pss_pkg::MODE_STAND_BY;
				end else if ((period_q != '0) && (rem == '0)) begin
					trig_n = 1'b1;
					if (remain_q != pss_pkg::COUNT_ENDLESS) begin
						remain_n = remain_q - pss_pkg::DATA_W'(1);
					end
				end
			end
			elapsed_n = elapsed_q + COUNTER_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q      <= action;
			req_q      <= requested_mode;
			step_q     <= step_seconds;
			count_in_q <= sample_count;
		end
		if (cmd.commit) begin
			ok_q        <= ok_n;
			trig_q      <= trig_n;
			samp_q      <= mode_n;
			res_count_q <= remain_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b1;
			pend_q    <= pss_pkg::MODE_STAND_BY;
			period_q  <= pss_pkg::RESET_PERIOD;
			remain_q  <= pss_pkg::COUNT_ENDLESS;
			elapsed_q <= '0;
		end else if (cmd.commit) begin
			mode_q    <= mode_n;
			pend_q    <= pend_n;
			period_q  <= period_n;
			remain_q  <= remain_n;
			elapsed_q <= elapsed_n;
		end
	end

	assign accepted          = ok_q;
	assign sample_trigger    = trig_q;
	assign sampling_now      = samp_q;
	assign samples_remaining = res_count_q;

endmodule

/* rtl/pss_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences capture, remainder and commit, and owns both handshakes.
// Depends on pss_pkg.

module pss_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  action,
	output logic                  result_valid,
	input  logic                  result_stall,
	output pss_pkg::pss_cmd_t     cmd,
	input  pss_pkg::pss_status_t  status
);

	pss_pkg::pss_state_t state_q;
	pss_pkg::pss_state_t state_n;
	logic                full_q;
	logic                slot_free;
	logic                take;

	assign take      = item_valid && !item_stall;
	// The result register can be reloaded when empty or when it drains this cycle.
	assign slot_free = !full_q || !result_stall;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pss_pkg::ST_IDLE: begin
				if (take) begin
					state_n = (action == pss_pkg::ACTION_TICK) ? pss_pkg::ST_DIVIDE
						: pss_pkg::ST_COMMIT;
				end
			end
			pss_pkg::ST_DIVIDE: begin
				if (status.div_done) begin
					state_n = pss_pkg::ST_COMMIT;
				end
			end
			pss_pkg::ST_COMMIT: begin
				if (slot_free) begin
					state_n = pss_pkg::ST_IDLE;
				end
			end
			default: state_n = pss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall    = 1'b1;
		cmd.capture   = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			pss_pkg::ST_IDLE: begin
				item_stall    = 1'b0;
				cmd.capture   = item_valid;
				cmd.div_start = item_valid && (action == pss_pkg::ACTION_TICK);
			end
			pss_pkg::ST_DIVIDE: begin
			end
			pss_pkg::ST_COMMIT: begin
				cmd.commit = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pss_pkg::ST_IDLE;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				full_q <= 1'b1;
			end else if (!result_stall) begin
				full_q <= 1'b0;
			end
		end
	end

	assign result_valid = full_q;

endmodule

/* rtl/periodic_sample_sequencer.sv */
`timescale 1ns / 1ps
// Periodic sample sequencer. A set command is captured and then committed to its
// result; a tick is captured, then waits in the divide state for the bit-serial
// remainder unit that computes elapsed modulo period one dividend bit per cycle,
// and is then committed. One transaction is in work at a time; the input
// accepts the next transaction while a finished result waits in the output
// register. Every accepted transaction yields exactly one result.

module periodic_sample_sequencer #(
	parameter int COUNTER_WIDTH = pss_pkg::DEFAULT_COUNTER_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               action,
	input  logic [1:0]                         requested_mode,
	input  logic [pss_pkg::DATA_W-1:0]         step_seconds,
	input  logic signed [pss_pkg::DATA_W-1:0]  sample_count,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               accepted,
	output logic                               sample_trigger,
	output logic                               sampling_now,
	output logic signed [pss_pkg::DATA_W-1:0]  samples_remaining
);

	pss_pkg::pss_cmd_t    cmd;
	pss_pkg::pss_status_t status;

	pss_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cmd(cmd),
		.status(status)
	);

	pss_dp #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.action(action),
		.requested_mode(requested_mode),
		.step_seconds(step_seconds),
		.sample_count(sample_count),
		.accepted(accepted),
		.sample_trigger(sample_trigger),
		.sampling_now(sampling_now),
		.samples_remaining(samples_remaining)
	);

endmodule
